// File: hdl/vrrq_pkg.sv
// ----------------------------------------------------------------------------
// vrrq_pkg
// Shared types, codes and helpers for the variable record ring queue.
// ----------------------------------------------------------------------------
package vrrq_pkg;

    localparam int STORE_BYTES_DEF = 4096;
    localparam int CAP_LIMIT       = 4096;
    localparam int HEADER_BYTES    = 8;
    localparam int POS_W           = 13;
    localparam int LEN_W           = 12;
    localparam int CAP_MIN         = 16;
    localparam int APB_ADDR_W      = 3;
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

    localparam logic [1:0] CMD_PUSH       = 2'd0;
    localparam logic [1:0] CMD_POP        = 2'd1;
    localparam logic [1:0] CMD_READ_FRONT = 2'd2;
    localparam logic [1:0] CMD_READ_BACK  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_OFF_RANGE = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [11:0] entry_length;
        logic        last_byte;
        logic [11:0] byte_offset;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic [11:0] entry_size;
        logic [31:0] stored_checksum;
        logic [12:0] entry_count;
        logic [12:0] used_bytes;
        logic [11:0] max_alloc;
    } t_out_item;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC32C_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// File: hdl/vrrq_ram.sv
// ----------------------------------------------------------------------------
// vrrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/variable_record_ring_queue.sv
// ----------------------------------------------------------------------------
// variable_record_ring_queue
// Ring store of variable-length records with size and CRC-32C headers.
// A push byte of an accepted record is written to the store; an accepted first
// byte adds header writes of the length word, and of a slack marker where
// needed, and a completing last byte adds a write of the CRC.
// A pop or read makes up to four 4-byte reads on the single byte-wide RAM
// port before its result is given.
// One item is in work at a time; the next transfer can be taken in the cycle
// the result appears, and a result that is held off waits in an output register.
// Synchronous reset empties the queue and sets the capacity register to 4096 bytes.
// ----------------------------------------------------------------------------
module variable_record_ring_queue #(
    parameter int STORE_BYTES = vrrq_pkg::STORE_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  vrrq_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output vrrq_pkg::t_out_item               o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vrrq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import vrrq_pkg::*;

    localparam int MEM_DEPTH = (STORE_BYTES < CAP_LIMIT) ? STORE_BYTES : CAP_LIMIT;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [POS_W-1:0] CAP_MAX = POS_W'(MEM_DEPTH);
    localparam logic [POS_W-1:0] CAP_LO  = POS_W'(CAP_MIN);
    localparam logic [POS_W-1:0] HDR     = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] CAP_RST = POS_W'(CAP_LIMIT);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_HDR  = 4'd2;
    localparam logic [3:0] S_BYTE = 4'd3;
    localparam logic [3:0] S_WR   = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] H_SLK  = 4'd6;
    localparam logic [3:0] H_LEN  = 4'd7;
    localparam logic [3:0] H_CK   = 4'd8;
    localparam logic [3:0] H_RB   = 4'd9;
    localparam logic [3:0] H_NXT  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]       r_state;
    logic [3:0]       r_ret;
    logic [2:0]       r_cnt;
    logic [POS_W-1:0] r_addr;
    logic [31:0]      r_word;
    t_in_item         r_in;

    logic [POS_W-1:0] r_cap_raw;
    logic [POS_W-1:0] r_rd_pos;
    logic [POS_W-1:0] r_wr_pos;
    logic [POS_W-1:0] r_last_bytes;
    logic [POS_W-1:0] r_rec_count;
    logic             r_push_active;
    logic             r_push_accepted;
    logic [POS_W-1:0] r_push_cursor;
    logic [POS_W-1:0] r_push_start;
    logic [LEN_W-1:0] r_push_len;
    logic [31:0]      r_crc;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_next;
    logic [31:0]      r_len;
    logic [2:0]       r_status;
    logic [7:0]       r_rb;
    logic [LEN_W-1:0] r_es;
    logic [31:0]      r_ck;

    logic             r_out_valid;
    t_out_item        r_out;

    logic [POS_W-1:0] cap;
    logic             cfg_wr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;

    logic [POS_W-1:0] sz;
    logic [2:0]       acc_code;
    logic [POS_W-1:0] acc_start;
    logic             acc_slack;
    logic [POS_W-1:0] push_end;
    logic             byte_wr;
    logic [31:0]      crc_upd;
    logic [POS_W-1:0] cur_upd;
    logic [POS_W-1:0] pop_next;
    logic [POS_W-1:0] cnt_dec;
    logic [POS_W-1:0] used;
    logic [POS_W-1:0] ma_raw;
    logic [LEN_W-1:0] ma;
    logic [31:0]      word_in;

    always_comb begin
        if (r_cap_raw > CAP_MAX) begin
            cap = CAP_MAX;
        end else if (r_cap_raw < CAP_LO) begin
            cap = CAP_LO;
        end else begin
            cap = r_cap_raw;
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == 1'b0);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == 1'b0) ? {19'd0, r_cap_raw} : 32'd0;

    always_comb begin
        sz        = {1'b0, r_in.entry_length} + HDR;
        acc_code  = ST_OK;
        acc_start = r_wr_pos;
        acc_slack = 1'b0;
        if (r_in.entry_length == '0) begin
            acc_code = ST_BAD_LEN;
        end else if (sz > cap) begin
            acc_code = ST_NO_SPACE;
        end else if (r_rec_count != '0) begin
            if (r_rd_pos < r_wr_pos) begin
                if ((cap - r_wr_pos) < sz) begin
                    if (r_rd_pos <= sz) begin
                        acc_code = ST_NO_SPACE;
                    end else begin
                        acc_slack = (r_wr_pos + HDR) <= cap;
                        acc_start = '0;
                    end
                end
            end else if ((r_rd_pos - r_wr_pos) <= sz) begin
                acc_code = ST_NO_SPACE;
            end
        end
    end

    assign push_end = r_push_start + HDR + {1'b0, r_push_len};
    assign byte_wr  = r_push_accepted && (r_push_cursor < push_end);
    assign crc_upd  = byte_wr ? crc32c_byte(r_crc, r_in.data_byte) : r_crc;
    assign cur_upd  = (r_push_cursor <= push_end) ? r_push_cursor + 1'b1 : r_push_cursor;
    assign word_in  = {mem_rdata, r_word[31:8]};
    assign pop_next = r_pos + HDR + r_word[POS_W-1:0];
    assign cnt_dec  = r_rec_count - 1'b1;

    always_comb begin
        used = (r_rd_pos > r_wr_pos) ? cap + r_wr_pos - r_rd_pos : r_wr_pos - r_rd_pos;
        if (r_rd_pos == r_wr_pos) begin
            ma_raw = cap;
        end else if (r_rd_pos < r_wr_pos) begin
            ma_raw = cap - r_wr_pos;
            if ((r_rd_pos != '0) && ((r_rd_pos - 1'b1) > ma_raw)) begin
                ma_raw = r_rd_pos - 1'b1;
            end
        end else begin
            ma_raw = r_rd_pos - r_wr_pos - 1'b1;
        end
        ma = (ma_raw > HDR) ? LEN_W'(ma_raw - HDR) : '0;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(r_addr + POS_W'(r_cnt));
        mem_wdata = r_word[8*r_cnt[1:0] +: 8];
        mem_raddr = AW'(r_addr + POS_W'(r_cnt));
        if (r_state == S_WR) begin
            mem_we = 1'b1;
        end else if (r_state == S_BYTE) begin
            mem_we    = byte_wr;
            mem_waddr = AW'(r_push_cursor);
            mem_wdata = r_in.data_byte;
        end
    end

    vrrq_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ret           <= S_IDLE;
            r_cnt           <= '0;
            r_cap_raw       <= CAP_RST;
            r_rd_pos        <= '0;
            r_wr_pos        <= '0;
            r_last_bytes    <= '0;
            r_rec_count     <= '0;
            r_push_active   <= 1'b0;
            r_push_accepted <= 1'b0;
            r_push_cursor   <= '0;
            r_push_start    <= '0;
            r_crc           <= '1;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_cap_raw       <= pwdata[POS_W-1:0];
                r_rd_pos        <= '0;
                r_wr_pos        <= '0;
                r_last_bytes    <= '0;
                r_rec_count     <= '0;
                r_push_active   <= 1'b0;
                r_push_accepted <= 1'b0;
                r_push_cursor   <= '0;
                r_push_start    <= '0;
                r_crc           <= '1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_status <= ST_OK;
                    r_rb     <= '0;
                    r_es     <= '0;
                    r_ck     <= '0;
                    r_cnt    <= '0;
                    unique case (r_in.cmd)
                        CMD_PUSH: begin
                            if (!r_push_active) begin
                                r_push_active <= 1'b1;
                                if (acc_code != ST_OK) begin
                                    r_push_accepted <= 1'b0;
                                    r_push_start    <= POS_W'(acc_code);
                                    r_state         <= S_BYTE;
                                end else begin
                                    r_push_accepted <= 1'b1;
                                    r_push_start    <= acc_start;
                                    r_push_len      <= r_in.entry_length;
                                    r_push_cursor   <= acc_start + HDR;
                                    r_crc           <= '1;
                                    if (acc_slack) begin
                                        r_addr  <= r_wr_pos;
                                        r_word  <= '0;
                                        r_ret   <= S_HDR;
                                        r_state <= S_WR;
                                    end else begin
                                        r_state <= S_HDR;
                                    end
                                end
                            end else begin
                                r_state <= S_BYTE;
                            end
                        end
                        CMD_READ_BACK: begin
                            if (r_rec_count == '0 || r_wr_pos < r_last_bytes) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_pos   <= r_wr_pos - r_last_bytes;
                                r_addr  <= r_wr_pos - r_last_bytes;
                                r_ret   <= H_LEN;
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                            if (r_rec_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else if (r_rd_pos > r_wr_pos) begin
                                if ((r_rd_pos + HDR) > cap) begin
                                    r_pos  <= '0;
                                    r_addr <= '0;
                                    r_ret  <= H_LEN;
                                end else begin
                                    r_addr <= r_rd_pos;
                                    r_ret  <= H_SLK;
                                end
                                r_state <= S_RD;
                            end else begin
                                r_pos   <= r_rd_pos;
                                r_addr  <= r_rd_pos;
                                r_ret   <= H_LEN;
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_HDR: begin
                    r_addr  <= r_push_start;
                    r_word  <= {20'd0, r_push_len};
                    r_cnt   <= '0;
                    r_ret   <= S_BYTE;
                    r_state <= S_WR;
                end
                S_BYTE: begin
                    r_state <= S_DONE;
                    if (r_push_accepted) begin
                        r_crc         <= crc_upd;
                        r_push_cursor <= cur_upd;
                        if (r_in.last_byte) begin
                            r_push_active   <= 1'b0;
                            r_push_accepted <= 1'b0;
                            if (cur_upd == push_end) begin
                                r_wr_pos     <= push_end;
                                r_last_bytes <= {1'b0, r_push_len} + HDR;
                                r_rec_count  <= r_rec_count + 1'b1;
                                r_es         <= r_push_len;
                                r_ck         <= ~crc_upd;
                                r_word       <= ~crc_upd;
                                r_addr       <= r_push_start + POS_W'(4);
                                r_cnt        <= '0;
                                r_ret        <= S_DONE;
                                r_state      <= S_WR;
                            end else begin
                                r_status <= ST_BAD_LEN;
                                if (r_rec_count == '0) begin
                                    r_rd_pos <= '0;
                                    r_wr_pos <= '0;
                                end
                            end
                        end
                    end else begin
                        r_status <= r_push_start[2:0];
                        if (r_in.last_byte) begin
                            r_push_active   <= 1'b0;
                            r_push_accepted <= 1'b0;
                            if (r_rec_count == '0) begin
                                r_rd_pos <= '0;
                                r_wr_pos <= '0;
                            end
                        end
                    end
                end
                S_WR: begin
                    if (r_cnt == 3'd3) begin
                        r_cnt   <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RD: begin
                    if (r_cnt != 3'd0) begin
                        r_word <= word_in;
                    end
                    if (r_cnt == 3'd4) begin
                        r_cnt   <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                H_SLK: begin
                    if (r_word == '0) begin
                        r_pos  <= '0;
                        r_addr <= '0;
                    end else begin
                        r_pos  <= r_rd_pos;
                        r_addr <= r_rd_pos;
                    end
                    r_ret   <= H_LEN;
                    r_state <= S_RD;
                end
                H_LEN: begin
                    r_len <= r_word;
                    if (r_in.cmd == CMD_POP) begin
                        r_rec_count <= cnt_dec;
                        r_state     <= S_DONE;
                        if (cnt_dec == '0) begin
                            if (r_push_active && r_push_accepted) begin
                                r_rd_pos <= r_wr_pos;
                            end else begin
                                r_rd_pos <= '0;
                                r_wr_pos <= '0;
                            end
                        end else if (pop_next > r_wr_pos) begin
                            if ((pop_next + HDR) > cap) begin
                                r_rd_pos <= '0;
                            end else begin
                                r_next  <= pop_next;
                                r_addr  <= pop_next;
                                r_ret   <= H_NXT;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_rd_pos <= pop_next;
                        end
                    end else begin
                        r_es    <= r_word[LEN_W-1:0];
                        r_addr  <= r_pos + POS_W'(4);
                        r_ret   <= H_CK;
                        r_state <= S_RD;
                    end
                end
                H_CK: begin
                    r_ck <= r_word;
                    if ({20'd0, r_in.byte_offset} >= r_len) begin
                        r_status <= ST_OFF_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_addr  <= r_pos + HDR + {1'b0, r_in.byte_offset};
                        r_ret   <= H_RB;
                        r_state <= S_RD;
                    end
                end
                H_RB: begin
                    r_rb    <= r_word[7:0];
                    r_state <= S_DONE;
                end
                H_NXT: begin
                    r_rd_pos <= (r_word == '0) ? '0 : r_next;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out.status          <= r_status;
            r_out.read_byte       <= r_rb;
            r_out.entry_size      <= r_es;
            r_out.stored_checksum <= r_ck;
            r_out.entry_count     <= r_rec_count;
            r_out.used_bytes      <= used;
            r_out.max_alloc       <= ma;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_push_accepted |-> r_push_active)
        else $error("accepted push without an active push");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_count == '0) |-> (r_rd_pos == r_wr_pos))
        else $error("empty queue with differing positions");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos <= cap)
        else $error("write position beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pos <= cap)
        else $error("read position beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BYTE) |-> r_push_active)
        else $error("push byte handled without an active push");

endmodule
